// ===== src/fha_pkg.sv =====
// ---------------------------------------------------------------------------
// fha_pkg
// Types, codes and helpers for the first-fit heap allocator.
// ---------------------------------------------------------------------------
package fha_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 20;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W      = ADDR_BITS + 1;
    localparam int HDR_W      = 7;
    localparam int SUM_W      = ADDR_BITS + 2;

    localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(65536);
    localparam logic [HDR_W-1:0] HEADER_RESET = HDR_W'(24);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_NULL      = 3'd4,
        ST_UNKNOWN   = 3'd5
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEXT_RD,
        S_MERGE,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
    } entry_t;

    function automatic logic [ADDR_BITS-1:0] sat_size(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] lim;
        lim = {{(SUM_W-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
        return (v > lim) ? {ADDR_BITS{1'b1}} : v[ADDR_BITS-1:0];
    endfunction

endpackage

// ===== src/first_fit_heap_allocator_core.sv =====
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with coalescing; block table held in one RAM.
// ---------------------------------------------------------------------------
//  channel   | direction | transaction
//  s_axis    | in        | command (tuser), request_size / payload_address
//  m_axis    | out       | result_address, status; one per command
//  apb       | in/out    | heap_limit @0x0, header_bytes @0x4
//
//  Flow: zero-size / null commands go straight to the answer after acceptance;
//  a scan reads one entry per cycle through the registered-read RAM; a matched
//  free then reads the following entry and writes the freed or merged entry, and
//  coalescing moves each later entry down. After each answer the core returns
//  to idle before the next acceptance. Reset clears entry count and break.
//  s_tready is high only in idle; a held result stalls the next completion.
module first_fit_heap_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_size [19:0], payload_address [39:20]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_address [19:0], status [22:20], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fha_pkg::*;

    entry_t mem [MAX_BLOCKS];

    state_t               state_reg, state_next;
    logic [LIM_W-1:0]     limit_reg;
    logic [HDR_W-1:0]     hdr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LIM_W-1:0]     brk_reg, brk_next;
    logic                 cmd_reg;
    logic [ADDR_BITS-1:0] size_reg, paddr_reg;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    entry_t               prev_reg, prev_next;
    entry_t               cur_reg, cur_next;
    logic [IDX_W-1:0]     hit_reg, hit_next;
    logic                 nval_reg, nval_next;
    logic [1:0]           rm_reg, rm_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    status_t              res_st_reg, res_st_next;
    logic                 out_v_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    status_t              out_st_reg;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rdata;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic                 in_acc, hit, scan_end, out_free;
    logic [LIM_W-1:0]     hdr_ext;
    logic [SUM_W-1:0]     app_end;
    logic [SUM_W-1:0]     s_prev, s_next, s_both;
    logic                 pfree, nfree;

    assign hdr_ext  = {{(LIM_W-HDR_W){1'b0}}, hdr_reg};
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_v_reg || m_tready;

    // RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata <= mem[rd_addr];
        end
    end

    // scan compare on the entry read last cycle; append end and merge sizes
    always_comb
    begin
        if (cmd_reg == CMD_ALLOC)
        begin
            hit = pend_reg && rdata.free && (rdata.size >= size_reg);
        end
        else
        begin
            hit = pend_reg && (({1'b0, rdata.start} + hdr_ext) == {1'b0, paddr_reg});
        end
        scan_end = !pend_reg && (issue_reg >= count_reg);
        app_end  = {1'b0, brk_reg} + SUM_W'(hdr_reg) + SUM_W'(size_reg);
        pfree    = (hit_reg != '0) && prev_reg.free;
        nfree    = nval_reg && rdata.free;
        s_prev   = SUM_W'(prev_reg.size) + SUM_W'(hdr_reg) + SUM_W'(cur_reg.size);
        s_next   = SUM_W'(cur_reg.size) + SUM_W'(hdr_reg) + SUM_W'(rdata.size);
        s_both   = SUM_W'(sat_size(s_prev)) + SUM_W'(hdr_reg) + SUM_W'(rdata.size);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if ((s_tuser == CMD_ALLOC && s_tdata[19:0] == '0) ||
                        (s_tuser == CMD_FREE && s_tdata[39:20] == '0))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (cmd_reg == CMD_ALLOC) ? S_DONE : S_NEXT_RD;
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_NEXT_RD:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                state_next = (pfree || nfree) ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                if (!pend_reg && issue_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        s_tready      = (state_reg == S_IDLE);
        count_next    = count_reg;
        brk_next      = brk_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        hit_next      = hit_reg;
        nval_next     = nval_reg;
        rm_next       = rm_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        rd_en         = 1'b0;
        rd_addr       = issue_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = pidx_reg;
        wr_data       = rdata;
        case (state_reg)
            S_IDLE:
            begin
                issue_next    = '0;
                pend_next     = 1'b0;
                res_addr_next = '0;
                res_st_next   = ST_OK;
                if (s_tuser == CMD_ALLOC && s_tdata[19:0] == '0)
                begin
                    res_st_next = ST_ZERO;
                end
                else if (s_tuser == CMD_FREE && s_tdata[39:20] == '0)
                begin
                    res_st_next = ST_NULL;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = pidx_reg;
                        wr_data       = rdata;
                        wr_data.free  = 1'b0;
                        res_addr_next = rdata.start + ADDR_BITS'(hdr_reg);
                    end
                    else
                    begin
                        hit_next = pidx_reg;
                        cur_next = rdata;
                    end
                end
                else if (scan_end)
                begin
                    if (cmd_reg == CMD_FREE)
                    begin
                        res_st_next = ST_UNKNOWN;
                    end
                    else if (app_end > SUM_W'(limit_reg) ||
                             app_end > SUM_W'(1 << ADDR_BITS))
                    begin
                        res_st_next = ST_EXHAUSTED;
                    end
                    else if (count_reg == CNT_W'(MAX_BLOCKS))
                    begin
                        res_st_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = count_reg[IDX_W-1:0];
                        wr_data.start = brk_reg[ADDR_BITS-1:0];
                        wr_data.size  = size_reg;
                        wr_data.free  = 1'b0;
                        count_next    = count_reg + CNT_W'(1);
                        brk_next      = app_end[LIM_W-1:0];
                        res_addr_next = brk_reg[ADDR_BITS-1:0] + ADDR_BITS'(hdr_reg);
                    end
                end
                else
                begin
                    if (pend_reg)
                    begin
                        prev_next = rdata;
                    end
                    if (issue_reg < count_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = issue_reg[IDX_W-1:0];
                        pidx_next  = issue_reg[IDX_W-1:0];
                        issue_next = issue_reg + CNT_W'(1);
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            S_NEXT_RD:
            begin
                nval_next = (CNT_W'(hit_reg) + CNT_W'(1)) < count_reg;
                rd_en     = 1'b1;
                rd_addr   = hit_reg + IDX_W'(1);
            end
            S_MERGE:
            begin
                wr_en     = 1'b1;
                pend_next = 1'b0;
                if (pfree && nfree)
                begin
                    wr_addr      = hit_reg - IDX_W'(1);
                    wr_data      = prev_reg;
                    wr_data.size = sat_size(s_both);
                    rm_next      = 2'd2;
                    issue_next   = CNT_W'(hit_reg) + CNT_W'(2);
                end
                else if (pfree)
                begin
                    wr_addr      = hit_reg - IDX_W'(1);
                    wr_data      = prev_reg;
                    wr_data.size = sat_size(s_prev);
                    rm_next      = 2'd1;
                    issue_next   = CNT_W'(hit_reg) + CNT_W'(1);
                end
                else if (nfree)
                begin
                    wr_addr      = hit_reg;
                    wr_data      = cur_reg;
                    wr_data.size = sat_size(s_next);
                    wr_data.free = 1'b1;
                    rm_next      = 2'd1;
                    issue_next   = CNT_W'(hit_reg) + CNT_W'(2);
                end
                else
                begin
                    wr_addr      = hit_reg;
                    wr_data      = cur_reg;
                    wr_data.free = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // read entry k, write it to k - rm in the cycle after
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg - IDX_W'(rm_reg);
                    wr_data = rdata;
                end
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = issue_reg[IDX_W-1:0];
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(rm_reg);
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        if (res_st_next != ST_OK)
        begin
            res_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            brk_reg   <= '0;
            pend_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            limit_reg <= LIMIT_RESET;
            hdr_reg   <= HEADER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            brk_reg   <= brk_next;
            pend_reg  <= pend_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            if (psel && penable && pwrite)
            begin
                if (paddr[2])
                begin
                    hdr_reg <= pwdata[HDR_W-1:0];
                end
                else
                begin
                    limit_reg <= pwdata[LIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        pidx_reg     <= pidx_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        hit_reg      <= hit_next;
        nval_reg     <= nval_next;
        rm_reg       <= rm_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        if (in_acc)
        begin
            cmd_reg   <= s_tuser;
            size_reg  <= s_tdata[19:0];
            paddr_reg <= s_tdata[39:20];
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_addr_reg <= res_addr_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, out_st_reg, out_addr_reg};
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? {{(32-HDR_W){1'b0}}, hdr_reg}
                               : {{(32-LIM_W){1'b0}}, limit_reg};

endmodule
